// File: rtl/plyft_pkg.sv
// Shared types and constants for the PLY face-list triangulator.
// Used by plyft_parse and ply_face_list_triangulator_top; no dependencies.
package plyft_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_COUNT_WIDTH = 2'd0;
  localparam logic [1:0] CFG_INDEX_WIDTH = 2'd1;
  localparam logic [1:0] CFG_BIG_ENDIAN  = 2'd2;
  localparam logic [1:0] CFG_REVERSE     = 2'd3;

  // Field width codes; any other code means four bytes.
  localparam logic [1:0] WIDTH_1B = 2'd0;
  localparam logic [1:0] WIDTH_2B = 2'd1;
  localparam logic [1:0] WIDTH_4B = 2'd2;

  // Progress through the first indices of a face.
  localparam logic [1:0] SEEN_NONE = 2'd0;
  localparam logic [1:0] SEEN_ONE  = 2'd1;
  localparam logic [1:0] SEEN_FULL = 2'd2;

  localparam logic [31:0] MIN_FACE_COUNT = 32'd3;

  typedef struct packed {
    logic [1:0] count_width_code;
    logic [1:0] index_width_code;
    logic       big_endian;
    logic       reverse_winding;
  } cfg_t;

  typedef struct packed {
    logic [31:0] corner_first;
    logic [31:0] corner_second;
    logic [31:0] corner_third;
    logic        face_done;
    logic        bad_face;
  } tri_t;

  // True when the byte at position pos is the last byte of a field of this width.
  function automatic logic field_last(input logic [1:0] code, input logic [1:0] pos);
    logic last;
    case (code)
      WIDTH_1B: last = 1'b1;
      WIDTH_2B: last = (pos != 2'd0);
      default:  last = (pos == 2'd3);
    endcase
    return last;
  endfunction

endpackage

// File: rtl/ply_face_list_triangulator_top.sv
// A triangle or error result passes through the input register, which takes its byte at
// acceptance, and then the result register.
// Throughput: one byte per cycle while the result side takes its requests; while a
// result is held, one more byte enters the input register and then the input stalls.
// Synchronous active-high rst clears the handshake, configuration (count width one byte,
// index width four bytes, little endian, normal winding) and all parse state.
module ply_face_list_triangulator_top
  import plyft_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        section_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] corner_first,
  output logic [31:0] corner_second,
  output logic [31:0] corner_third,
  output logic        face_done,
  output logic        bad_face,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [1:0]  cfg_data
);

  cfg_t       cfg;
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_start;
  logic       out_free;
  logic       s1_advance;
  logic       result_valid;
  tri_t       result;
  tri_t       out_reg;

  assign out_free   = !out_valid || out_ready;
  assign s1_advance = s1_valid && out_free;
  assign in_ready   = !s1_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.count_width_code <= WIDTH_1B;
      cfg.index_width_code <= WIDTH_4B;
      cfg.big_endian       <= 1'b0;
      cfg.reverse_winding  <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_COUNT_WIDTH: cfg.count_width_code <= cfg_data;
        CFG_INDEX_WIDTH: cfg.index_width_code <= cfg_data;
        CFG_BIG_ENDIAN:  cfg.big_endian       <= cfg_data[0];
        CFG_REVERSE:     cfg.reverse_winding  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte  <= data_byte;
      s1_start <= section_start;
    end
  end

  plyft_parse u_parse (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .step         (s1_advance),
    .data_byte    (s1_byte),
    .section_start(s1_start),
    .result_valid (result_valid),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance && result_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && result_valid) begin
      out_reg <= result;
    end
  end

  assign corner_first  = out_reg.corner_first;
  assign corner_second = out_reg.corner_second;
  assign corner_third  = out_reg.corner_third;
  assign face_done     = out_reg.face_done;
  assign bad_face      = out_reg.bad_face;

`ifndef ASSERT_OFF
  // An error result carries zero corners and closes the face.
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_face |-> face_done && corner_first == 32'd0
      && corner_second == 32'd0 && corner_third == 32'd0)
    else $error("error result with nonzero corners");

  // A held byte in the input register is never dropped.
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_advance |=> s1_valid)
    else $error("input register lost a byte");

  // The parser never steps while a result waits to be taken.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !s1_advance)
    else $error("parser stepped over a waiting result");
`endif

endmodule

// File: rtl/plyft_parse.sv
// Face-list parser: byte assembly, face count check and fan triangle generation.
// Depends on plyft_pkg. Parse state advances on each step; the result is combinational.
module plyft_parse
  import plyft_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       step,
  input  logic [7:0] data_byte,
  input  logic       section_start,
  output logic       result_valid,
  output tri_t       result
);

  logic        reading_indices;
  logic [1:0]  byte_position;
  logic [31:0] word_accumulator;
  logic [31:0] indices_left;
  logic [1:0]  indices_seen;
  logic [31:0] fan_anchor;
  logic [31:0] previous_index;
  logic        error_latched;

  logic        reading_indices_next;
  logic [1:0]  byte_position_next;
  logic [31:0] word_accumulator_next;
  logic [31:0] indices_left_next;
  logic [1:0]  indices_seen_next;
  logic [31:0] fan_anchor_next;
  logic [31:0] previous_index_next;
  logic        error_latched_next;

  logic [31:0] acc_in;
  logic [1:0]  width_code;

  always_comb begin
    reading_indices_next  = reading_indices;
    byte_position_next    = byte_position;
    word_accumulator_next = word_accumulator;
    indices_left_next     = indices_left;
    indices_seen_next     = indices_seen;
    fan_anchor_next       = fan_anchor;
    previous_index_next   = previous_index;
    error_latched_next    = error_latched;
    result_valid          = 1'b0;
    result                = '0;
    acc_in                = '0;
    width_code            = cfg.count_width_code;

    // A section start clears everything, then the byte is parsed as the first count byte.
    if (section_start) begin
      reading_indices_next  = 1'b0;
      byte_position_next    = 2'd0;
      word_accumulator_next = '0;
      indices_left_next     = '0;
      indices_seen_next     = SEEN_NONE;
      fan_anchor_next       = '0;
      previous_index_next   = '0;
      error_latched_next    = 1'b0;
    end

    if (!error_latched_next) begin
      if (cfg.big_endian) begin
        acc_in = {word_accumulator_next[23:0], data_byte};
      end else begin
        acc_in = word_accumulator_next | ({24'd0, data_byte} << {byte_position_next, 3'b000});
      end
      width_code = reading_indices_next ? cfg.index_width_code : cfg.count_width_code;

      if (!field_last(width_code, byte_position_next)) begin
        word_accumulator_next = acc_in;
        byte_position_next    = byte_position_next + 2'd1;
      end else begin
        word_accumulator_next = '0;
        byte_position_next    = 2'd0;
        if (!reading_indices_next) begin
          if (acc_in < MIN_FACE_COUNT) begin
            error_latched_next = 1'b1;
            result_valid       = 1'b1;
            result.face_done   = 1'b1;
            result.bad_face    = 1'b1;
          end else begin
            indices_left_next    = acc_in;
            indices_seen_next    = SEEN_NONE;
            reading_indices_next = 1'b1;
          end
        end else begin
          indices_left_next = indices_left_next - 32'd1;
          case (indices_seen_next)
            SEEN_NONE: begin
              fan_anchor_next   = acc_in;
              indices_seen_next = SEEN_ONE;
            end
            SEEN_ONE: begin
              previous_index_next = acc_in;
              indices_seen_next   = SEEN_FULL;
            end
            default: begin
              result_valid        = 1'b1;
              result.corner_first = fan_anchor_next;
              if (cfg.reverse_winding) begin
                result.corner_second = acc_in;
                result.corner_third  = previous_index_next;
              end else begin
                result.corner_second = previous_index_next;
                result.corner_third  = acc_in;
              end
              result.face_done    = (indices_left_next == 32'd0);
              previous_index_next = acc_in;
            end
          endcase
          if (indices_left_next == 32'd0) begin
            reading_indices_next = 1'b0;
            indices_seen_next    = SEEN_NONE;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reading_indices  <= 1'b0;
      byte_position    <= 2'd0;
      word_accumulator <= '0;
      indices_left     <= '0;
      indices_seen     <= SEEN_NONE;
      fan_anchor       <= '0;
      previous_index   <= '0;
      error_latched    <= 1'b0;
    end else if (step) begin
      reading_indices  <= reading_indices_next;
      byte_position    <= byte_position_next;
      word_accumulator <= word_accumulator_next;
      indices_left     <= indices_left_next;
      indices_seen     <= indices_seen_next;
      fan_anchor       <= fan_anchor_next;
      previous_index   <= previous_index_next;
      error_latched    <= error_latched_next;
    end
  end

`ifndef ASSERT_OFF
  // While a count is expected, no index of a face has been seen.
  a_seen_idle: assert property (@(posedge clk) disable iff (rst)
    !reading_indices |-> indices_seen == SEEN_NONE)
    else $error("index progress set outside an index list");

  // The index progress counter saturates and never takes its unused code.
  a_seen_range: assert property (@(posedge clk) disable iff (rst)
    indices_seen != 2'd3)
    else $error("index progress out of range");

  // An error is latched only at a field boundary, and holds the assembly empty.
  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    error_latched |-> byte_position == 2'd0 && word_accumulator == 32'd0)
    else $error("partial field held while error latched");
`endif

endmodule
